### hdl/gpf_pkg.sv
// Shared constants for the gravity pair force block: field widths, register
// indexes, reset values and saturation limits.
// No dependencies.
`default_nettype none
package gpf_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int NUM_AXES      = 3;
    localparam int MASS_W        = 32;
    localparam int CFG_W         = 32;
    localparam int MUL_W         = 32;
    localparam int FORCE_W       = 48;
    localparam int CFG_IDX_W     = 1;
    localparam int OUT_DATA_W    = NUM_AXES * FORCE_W;
    localparam int OUT_USER_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRAV_COEFF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 1'd1;

    localparam logic [CFG_W-1:0] GRAV_COEFF_RST = 32'd18781;
    localparam logic [CFG_W-1:0] MIN_DIST_RST   = 32'd65536;

    localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_LIM = {1'b1, {(FORCE_W-1){1'b0}}};

    localparam int TUSER_TOO_CLOSE = 0;
    localparam int TUSER_SATURATED = 1;

endpackage
`default_nettype wire

### hdl/gravity_pair_force.sv
// Newtonian pair force pipeline: top level, built on gpf_pkg, gpf_isqrt and
// gpf_div.
// One body pair in, the force on the first body out.
`default_nettype none
// The block takes one body pair per clock cycle while the output is not
// stalled and returns the Newtonian attraction on the first body:
// grav_coeff * mass_a * mass_b / distance^2 along the unit vector towards
// the second body, in signed Q32.16 with saturation. The second body feels
// the negated force. The square root settles one bit of the distance per
// stage, and the divider, after its overflow check stage, settles one of the
// 48 quotient bits per stage. Every stage moves together: the pipeline
// advances whenever the output register is empty or its transaction is
// being taken, so a stall on the output side freezes every item in flight
// and none is lost or repeated. When the distance is at or below
// min_distance the force is zero and too_close is raised. The two
// configuration registers may be written at any cycle; they are read live by
// the pipeline, so they should only change while no pair is in flight.
module gravity_pair_force #(
    parameter int POS_WIDTH = gpf_pkg::POS_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    // Configuration write channel.
    input  logic                                             i_cfg_valid,
    output logic                                             o_cfg_ready,
    input  logic [gpf_pkg::CFG_IDX_W-1:0]                    i_cfg_index,
    input  logic [gpf_pkg::CFG_W-1:0]                        i_cfg_data,
    // Input stream.
    input  logic                                             i_s_axis_tvalid,
    output logic                                             o_s_axis_tready,
    // From bit 0: a_x, a_y, a_z, b_x, b_y, b_z, mass_a, mass_b, zero fill.
    input  logic [((6*POS_WIDTH+2*gpf_pkg::MASS_W+7)/8)*8-1:0] i_s_axis_tdata,
    // Output stream.
    output logic                                             o_m_axis_tvalid,
    input  logic                                             i_m_axis_tready,
    // From bit 0: force_x, force_y, force_z.
    output logic [gpf_pkg::OUT_DATA_W-1:0]                   o_m_axis_tdata,
    // From bit 0: too_close, saturated.
    output logic [gpf_pkg::OUT_USER_W-1:0]                   o_m_axis_tuser
);

    import gpf_pkg::*;

    localparam int PW     = POS_WIDTH;
    localparam int SW     = 2 * PW + 2;
    localparam int LW     = PW + 1;
    localparam int GM_W   = CFG_W + MASS_W;
    localparam int PP_W   = MUL_W + MASS_W;
    localparam int NB_W   = GM_W + MASS_W;
    localparam int NB_CH  = (NB_W + MUL_W - 1) / MUL_W;
    localparam int NUM_W  = NB_W + PW;
    localparam int S_CH   = (SW + MUL_W - 1) / MUL_W;
    localparam int SP_W   = S_CH * MUL_W;
    localparam int DSUM_W = SP_W + LW;
    localparam int DEN_W  = SW + LW;
    localparam int ZW     = (LW > CFG_W) ? LW : CFG_W;
    localparam int TAG1_W = SW + NUM_AXES * NUM_W + NUM_AXES;
    localparam int TAG2_W = NUM_AXES + 1;

    // Configuration registers. The port never pushes back.
    logic [CFG_W-1:0] r_grav;
    logic [CFG_W-1:0] r_min;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_COEFF_RST;
            r_min  <= MIN_DIST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRAV_COEFF: r_grav <= i_cfg_data;
                REG_MIN_DIST:   r_min  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances as one whenever the output register can
    // hand over or is empty.
    logic en;
    logic r_out_vld;

    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Stage 1: per-axis difference, split into magnitude and sign, and the
    // coefficient times the first mass.
    logic [NUM_AXES-1:0][PW:0]   d1;
    logic [NUM_AXES-1:0][PW-1:0] n1_mag, r1_mag;
    logic [NUM_AXES-1:0]         n1_neg, r1_neg;
    logic [GM_W-1:0]             n1_gm, r1_gm;
    logic [MASS_W-1:0]           r1_mb;
    logic                        r1_vld;
    logic [PW-1:0]               pa [NUM_AXES];
    logic [PW-1:0]               pb [NUM_AXES];
    logic [MASS_W-1:0]           in_mass_a, in_mass_b;

    assign in_mass_a = i_s_axis_tdata[6*PW +: MASS_W];
    assign in_mass_b = i_s_axis_tdata[6*PW+MASS_W +: MASS_W];
    assign n1_gm     = GM_W'(r_grav) * GM_W'(in_mass_a);

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            pa[a]     = i_s_axis_tdata[a*PW +: PW];
            pb[a]     = i_s_axis_tdata[(a+NUM_AXES)*PW +: PW];
            d1[a]     = {pb[a][PW-1], pb[a]} - {pa[a][PW-1], pa[a]};
            n1_neg[a] = d1[a][PW];
            n1_mag[a] = d1[a][PW] ? PW'(-d1[a]) : PW'(d1[a]);
        end
    end

    // Stage 2: squares of the magnitudes and the two halves of the mass
    // product.
    logic [NUM_AXES-1:0][2*PW-1:0] n2_sq, r2_sq;
    logic [PP_W-1:0]               n2_pp0, n2_pp1, r2_pp0, r2_pp1;
    logic [NUM_AXES-1:0][PW-1:0]   r2_mag;
    logic [NUM_AXES-1:0]           r2_neg;
    logic                          r2_vld;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n2_sq[a] = (2*PW)'(r1_mag[a]) * (2*PW)'(r1_mag[a]);
        end
    end
    assign n2_pp0 = PP_W'(r1_gm[MUL_W-1:0]) * PP_W'(r1_mb);
    assign n2_pp1 = PP_W'(r1_gm[GM_W-1:MUL_W]) * PP_W'(r1_mb);

    // Stage 3: squared distance and the full mass product.
    logic [SW-1:0]               n3_s, r3_s;
    logic [NB_W-1:0]             n3_nb, r3_nb;
    logic [NUM_AXES-1:0][PW-1:0] r3_mag;
    logic [NUM_AXES-1:0]         r3_neg;
    logic                        r3_vld;

    assign n3_s  = SW'(r2_sq[0]) + SW'(r2_sq[1]) + SW'(r2_sq[2]);
    assign n3_nb = NB_W'(r2_pp0) + (NB_W'(r2_pp1) << MUL_W);

    // Stage 4: partial products of the mass product with each magnitude.
    logic [NUM_AXES-1:0][NB_CH-1:0][MUL_W+PW-1:0] n4_pp, r4_pp;
    logic [SW-1:0]                                r4_s;
    logic [NUM_AXES-1:0]                          r4_neg;
    logic                                         r4_vld;
    logic [NB_CH*MUL_W-1:0]                       nb_pad;

    assign nb_pad = (NB_CH*MUL_W)'(r3_nb);

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int j = 0; j < NB_CH; j++) begin
                n4_pp[a][j] = (MUL_W+PW)'(nb_pad[j*MUL_W +: MUL_W]) *
                              (MUL_W+PW)'(r3_mag[a]);
            end
        end
    end

    // Stage 5: numerator per axis.
    logic [NUM_AXES-1:0][NUM_W-1:0] n5_num, r5_num;
    logic [SW-1:0]                  r5_s;
    logic [NUM_AXES-1:0]            r5_neg;
    logic                           r5_vld;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n5_num[a] = '0;
            for (int j = 0; j < NB_CH; j++) begin
                n5_num[a] = n5_num[a] + (NUM_W'(r4_pp[a][j]) << (j * MUL_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag <= n1_mag;
            r1_neg <= n1_neg;
            r1_gm  <= n1_gm;
            r1_mb  <= in_mass_b;
            r2_sq  <= n2_sq;
            r2_pp0 <= n2_pp0;
            r2_pp1 <= n2_pp1;
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
            r3_s   <= n3_s;
            r3_nb  <= n3_nb;
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r4_pp  <= n4_pp;
            r4_s   <= r3_s;
            r4_neg <= r3_neg;
            r5_num <= n5_num;
            r5_s   <= r4_s;
            r5_neg <= r4_neg;
        end
    end

    // Distance, floor of the square root of the squared distance.
    logic                           sq_vld;
    logic [LW-1:0]                  sq_root;
    logic [TAG1_W-1:0]              sq_tag;
    logic [SW-1:0]                  sq_s;
    logic [NUM_AXES-1:0][NUM_W-1:0] sq_num;
    logic [NUM_AXES-1:0]            sq_neg;

    gpf_isqrt #(
        .RAD_W  (SW),
        .ROOT_W (LW),
        .TAG_W  (TAG1_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r5_vld),
        .i_rad   (r5_s),
        .i_tag   ({r5_s, r5_num, r5_neg}),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    assign {sq_s, sq_num, sq_neg} = sq_tag;

    // Stage 6: minimum distance test and partial products of the divisor.
    logic [S_CH-1:0][MUL_W+LW-1:0]  n6_pp, r6_pp;
    logic [SP_W-1:0]                s_pad;
    logic                           n6_tc, r6_tc;
    logic [NUM_AXES-1:0][NUM_W-1:0] r6_num;
    logic [NUM_AXES-1:0]            r6_neg;
    logic                           r6_vld;

    assign s_pad = SP_W'(sq_s);
    assign n6_tc = ZW'(sq_root) <= ZW'(r_min);

    always_comb begin
        for (int j = 0; j < S_CH; j++) begin
            n6_pp[j] = (MUL_W+LW)'(s_pad[j*MUL_W +: MUL_W]) * (MUL_W+LW)'(sq_root);
        end
    end

    // Stage 7: divisor, squared distance times distance.
    logic [DSUM_W-1:0]              den_sum;
    logic [DEN_W-1:0]               r7_den;
    logic                           r7_tc;
    logic [NUM_AXES-1:0][NUM_W-1:0] r7_num;
    logic [NUM_AXES-1:0]            r7_neg;
    logic                           r7_vld;

    always_comb begin
        den_sum = '0;
        for (int j = 0; j < S_CH; j++) begin
            den_sum = den_sum + (DSUM_W'(r6_pp[j]) << (j * MUL_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= sq_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pp  <= n6_pp;
            r6_tc  <= n6_tc;
            r6_num <= sq_num;
            r6_neg <= sq_neg;
            r7_den <= DEN_W'(den_sum);
            r7_tc  <= r6_tc;
            r7_num <= r6_num;
            r7_neg <= r6_neg;
        end
    end

    // Force magnitude per axis.
    logic                             dv_vld;
    logic [NUM_AXES-1:0][FORCE_W-1:0] dv_quo;
    logic [NUM_AXES-1:0]              dv_ovf;
    logic [TAG2_W-1:0]                dv_tag;
    logic [NUM_AXES-1:0]              dv_neg;
    logic                             dv_tc;

    gpf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (FORCE_W),
        .TAG_W (TAG2_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r7_vld),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_tag   ({r7_neg, r7_tc}),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf),
        .o_tag   (dv_tag)
    );

    assign {dv_neg, dv_tc} = dv_tag;

    // Output register: clamp, apply the sign, and zero the force and the
    // saturation flag when the bodies are too close.
    logic [NUM_AXES-1:0][FORCE_W-1:0] cap, mag_q, n_force, r_force;
    logic [NUM_AXES-1:0]              over;
    logic                             n_sat, r_sat, r_tc;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            cap[a]     = dv_neg[a] ? FORCE_LIM : FORCE_MAX;
            over[a]    = dv_ovf[a] || (dv_quo[a] > cap[a]);
            mag_q[a]   = over[a] ? cap[a] : dv_quo[a];
            n_force[a] = dv_neg[a] ? -mag_q[a] : mag_q[a];
        end
        n_sat = |over;
        if (dv_tc) begin
            n_force = '0;
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_force <= n_force;
            r_sat   <= n_sat;
            r_tc    <= dv_tc;
        end
    end

    assign o_m_axis_tvalid                  = r_out_vld;
    assign o_m_axis_tdata                   = r_force;
    assign o_m_axis_tuser[TUSER_TOO_CLOSE]  = r_tc;
    assign o_m_axis_tuser[TUSER_SATURATED]  = r_sat;

endmodule
`default_nettype wire

### hdl/gpf_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband tag alongside; depends on nothing else.
`default_nettype none
module gpf_isqrt #(
    parameter int RAD_W  = 66,
    parameter int ROOT_W = 33,
    parameter int TAG_W  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output logic [TAG_W-1:0]  o_tag
);

    localparam int CMP_W = RAD_W + 1;

    logic              r_vld  [ROOT_W];
    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [TAG_W-1:0]  r_tag  [ROOT_W];

    logic              p_vld  [ROOT_W];
    logic [RAD_W-1:0]  p_rem  [ROOT_W];
    logic [ROOT_W-1:0] p_root [ROOT_W];
    logic [TAG_W-1:0]  p_tag  [ROOT_W];
    logic [CMP_W-1:0]  trial  [ROOT_W];
    logic [RAD_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    // Each stage tries the next lower root bit against the running remainder.
    always_comb begin
        p_vld[0]  = i_vld;
        p_rem[0]  = i_rad;
        p_root[0] = '0;
        p_tag[0]  = i_tag;
        for (int s = 1; s < ROOT_W; s++) begin
            p_vld[s]  = r_vld[s-1];
            p_rem[s]  = r_rem[s-1];
            p_root[s] = r_root[s-1];
            p_tag[s]  = r_tag[s-1];
        end
        for (int s = 0; s < ROOT_W; s++) begin
            trial[s] = (CMP_W'(p_root[s]) << (ROOT_W - s)) |
                       (CMP_W'(1) << (2 * (ROOT_W - 1 - s)));
            n_rem[s]  = p_rem[s];
            n_root[s] = p_root[s];
            if (CMP_W'(p_rem[s]) >= trial[s]) begin
                n_rem[s]  = RAD_W'(CMP_W'(p_rem[s]) - trial[s]);
                n_root[s] = p_root[s] | (ROOT_W'(1) << (ROOT_W - 1 - s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ROOT_W; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < ROOT_W; s++) r_vld[s] <= p_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < ROOT_W; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_tag[s]  <= p_tag[s];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_tag  = r_tag[ROOT_W-1];

endmodule
`default_nettype wire

### hdl/gpf_div.sv
// Pipelined restoring divider for three numerators over one shared divisor,
// with an overflow check stage in front. Depends on gpf_pkg.
`default_nettype none
module gpf_div #(
    parameter int NUM_W = 128,
    parameter int DEN_W = 99,
    parameter int QUO_W = 48,
    parameter int TAG_W = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_vld,
    input  logic [gpf_pkg::NUM_AXES-1:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]                        i_den,
    input  logic [TAG_W-1:0]                        i_tag,
    output logic                                    o_vld,
    output logic [gpf_pkg::NUM_AXES-1:0][QUO_W-1:0] o_quo,
    output logic [gpf_pkg::NUM_AXES-1:0]            o_ovf,
    output logic [TAG_W-1:0]                        o_tag
);

    import gpf_pkg::*;

    localparam int CMP_W = (DEN_W + QUO_W > NUM_W) ? DEN_W + QUO_W : NUM_W;
    localparam int NST   = QUO_W + 1;

    logic                             r_vld [NST];
    logic [NUM_AXES-1:0][NUM_W-1:0]   r_rem [NST];
    logic [NUM_AXES-1:0][QUO_W-1:0]   r_quo [NST];
    logic [NUM_AXES-1:0]              r_ovf [NST];
    logic [DEN_W-1:0]                 r_den [NST];
    logic [TAG_W-1:0]                 r_tag [NST];

    logic                             p_vld [NST];
    logic [NUM_AXES-1:0][NUM_W-1:0]   p_rem [NST];
    logic [NUM_AXES-1:0][QUO_W-1:0]   p_quo [NST];
    logic [NUM_AXES-1:0]              p_ovf [NST];
    logic [DEN_W-1:0]                 p_den [NST];
    logic [TAG_W-1:0]                 p_tag [NST];
    logic [CMP_W-1:0]                 dsh   [NST];
    logic [NUM_AXES-1:0][NUM_W-1:0]   n_rem [NST];
    logic [NUM_AXES-1:0][QUO_W-1:0]   n_quo [NST];
    logic [NUM_AXES-1:0]              n_ovf [NST];

    // The first stage only tests whether the quotient reaches 2^QUO_W; each
    // later stage settles one quotient bit, most significant first.
    always_comb begin
        p_vld[0] = i_vld;
        p_rem[0] = i_num;
        p_quo[0] = '0;
        p_ovf[0] = '0;
        p_den[0] = i_den;
        p_tag[0] = i_tag;
        for (int s = 1; s < NST; s++) begin
            p_vld[s] = r_vld[s-1];
            p_rem[s] = r_rem[s-1];
            p_quo[s] = r_quo[s-1];
            p_ovf[s] = r_ovf[s-1];
            p_den[s] = r_den[s-1];
            p_tag[s] = r_tag[s-1];
        end
        for (int s = 0; s < NST; s++) begin
            dsh[s]   = CMP_W'(p_den[s]) << (QUO_W - s);
            n_rem[s] = p_rem[s];
            n_quo[s] = p_quo[s];
            n_ovf[s] = p_ovf[s];
            for (int a = 0; a < NUM_AXES; a++) begin
                if (CMP_W'(p_rem[s][a]) >= dsh[s]) begin
                    if (s == 0) begin
                        n_ovf[s][a] = 1'b1;
                    end else begin
                        n_rem[s][a] = NUM_W'(CMP_W'(p_rem[s][a]) - dsh[s]);
                        n_quo[s][a] = p_quo[s][a] | (QUO_W'(1) << (QUO_W - s));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= p_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_ovf[s] <= n_ovf[s];
                r_den[s] <= p_den[s];
                r_tag[s] <= p_tag[s];
            end
        end
    end

    assign o_vld = r_vld[NST-1];
    assign o_quo = r_quo[NST-1];
    assign o_ovf = r_ovf[NST-1];
    assign o_tag = r_tag[NST-1];

endmodule
`default_nettype wire

### hdl/gpf_checker.sv
// Port-level checks for gravity_pair_force and the bind that attaches them.
// Depends on gpf_pkg and on the top level's ports.
`default_nettype none
module gpf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [gpf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic [gpf_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);

    import gpf_pkg::*;

    logic [FORCE_W-1:0] fx, fy, fz;

    assign fx = o_m_axis_tdata[0*FORCE_W +: FORCE_W];
    assign fy = o_m_axis_tdata[1*FORCE_W +: FORCE_W];
    assign fz = o_m_axis_tdata[2*FORCE_W +: FORCE_W];

    // A waiting result transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Bodies that are too close give no force and no clamp.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[TUSER_TOO_CLOSE] |->
            fx == '0 && fy == '0 && fz == '0 && !o_m_axis_tuser[TUSER_SATURATED])
        else $error("force present on too-close pair");

    // A clamped result shows at least one component at a limit.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[TUSER_SATURATED] |->
            fx == FORCE_MAX || fx == FORCE_LIM || fy == FORCE_MAX ||
            fy == FORCE_LIM || fz == FORCE_MAX || fz == FORCE_LIM)
        else $error("saturation flag without a clamped component");

endmodule

bind gravity_pair_force gpf_checker u_gpf_checker (.*);
`default_nettype wire
